// ===== design/cbba_pkg.sv =====
// Shared types and constants for the clipped banked blit addresser.
package cbba_pkg;

   // Screen geometry
   localparam int unsigned BANK_LINES   = 64;
   localparam int unsigned SCREEN_LINES = 192;
   localparam int unsigned BANK_BITS    = $clog2(BANK_LINES);
   localparam logic [8:0]  SCREEN_LAST  = 9'(SCREEN_LINES - 1);
   localparam logic [16:0] COLUMN_LAST  = 17'd255;

   // Register file geometry
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_DEST_X        = 3'd0,
      REG_DEST_Y        = 3'd1,
      REG_SRC_WIDTH     = 3'd2,
      REG_RECT_HEIGHT   = 3'd3,
      REG_TARGET_BUFFER = 3'd4
   } reg_index_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [7:0]  dest_x;
      logic [7:0]  dest_y;
      logic [15:0] src_width;
      logic [7:0]  rect_height;
      logic        target_buffer;
   } cfg_type;

   // One write to the frame buffer
   typedef struct packed {
      logic        buffer_sel;
      logic [1:0]  bank_sel;
      logic [13:0] bank_offset;
      logic [7:0]  pixel_out;
   } result_type;

endpackage

// ===== design/clipped_banked_blit_addresser.sv =====
// Top level of the clipped banked blit addresser.
//
// Source pixels enter on the req_ channel one byte per transaction, in
// row-major order with a stride of src_width. Each pixel that lands on the
// 256x192 screen leaves on the rsp_ channel as one write transaction:
// buffer, bank (screen row / 64), offset in bank and the pixel byte.
// Pixels off the right or bottom edge are consumed without a response.
// Registers are to be set over the csr_ APB-style port while the block is
// idle, not enforced by the block. A pixel taken is on rsp_ the cycle after.
// Throughput is one pixel per cycle, unless stalled; the counter compare
// and the position add sit between the counters and the output register.
// While rsp_stall holds a write, req_stall is raised so the output register
// and the counters hold; a free or draining output register takes a pixel
// every cycle. Reset clears the counters and the output valid and loads the
// register defaults (width and height 1, everything else 0).
module clipped_banked_blit_addresser
   import cbba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_buffer_sel,
   output logic [1:0]            rsp_bank_sel,
   output logic [13:0]           rsp_bank_offset,
   output logic [7:0]            rsp_pixel_out,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type next_result;
   result_type rsp_data;
   logic       emit;
   logic       req_fire;

   // Stall the input only while a write waits in a blocked output register
   assign req_stall = rsp_valid && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   cbba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbba_addr u_addr (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .advance  (req_fire),
      .pixel_in (req_pixel_in),
      .emit     (emit),
      .result   (next_result)
   );

   cbba_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire),
      .load_valid (emit),
      .load_data  (next_result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   assign rsp_buffer_sel  = rsp_data.buffer_sel;
   assign rsp_bank_sel    = rsp_data.bank_sel;
   assign rsp_bank_offset = rsp_data.bank_offset;
   assign rsp_pixel_out   = rsp_data.pixel_out;

   // A stalled input always means a write is pending at the output
   a_stall_has_write: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending write");

   // Only three banks exist on screen
   a_bank_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bank_sel != 2'd3))
      else $error("write addressed a bank past the bottom third");

   // A taken write with no new pixel leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_valid) |=> !rsp_valid)
      else $error("write repeated after it was taken");

   // A pixel accepted with zero size never produces a write
   a_zero_size: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ((cfg.src_width == 16'd0) || (cfg.rect_height == 8'd0)))
      |=> !rsp_valid)
      else $error("write produced for an empty rectangle");

endmodule

// ===== design/cbba_csr.sv =====
// APB-style configuration register file for the blit addresser.
module cbba_csr
   import cbba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_en;

   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_DEST_X:        cfg_in.dest_x        = csr_pwdata[7:0];
            REG_DEST_Y:        cfg_in.dest_y        = csr_pwdata[7:0];
            REG_SRC_WIDTH:     cfg_in.src_width     = csr_pwdata[15:0];
            REG_RECT_HEIGHT:   cfg_in.rect_height   = csr_pwdata[7:0];
            REG_TARGET_BUFFER: cfg_in.target_buffer = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x        <= '0;
         cfg_ff.dest_y        <= '0;
         cfg_ff.src_width     <= 16'd1;
         cfg_ff.rect_height   <= 8'd1;
         cfg_ff.target_buffer <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_index)
         REG_DEST_X:        csr_prdata = {24'd0, cfg_ff.dest_x};
         REG_DEST_Y:        csr_prdata = {24'd0, cfg_ff.dest_y};
         REG_SRC_WIDTH:     csr_prdata = {16'd0, cfg_ff.src_width};
         REG_RECT_HEIGHT:   csr_prdata = {24'd0, cfg_ff.rect_height};
         REG_TARGET_BUFFER: csr_prdata = {31'd0, cfg_ff.target_buffer};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

// ===== design/cbba_addr.sv =====
// Rectangle position counters, screen clipping and bank address generation.
module cbba_addr
   import cbba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       advance,
   input  logic [7:0] pixel_in,
   output logic       emit,
   output result_type result
);

   logic [15:0] column_count_ff, column_count_in;
   logic [7:0]  row_count_ff, row_count_in;
   logic        size_zero;
   logic [16:0] screen_col;
   logic [8:0]  screen_row;
   logic [16:0] column_next;
   logic [8:0]  row_next;

   assign size_zero  = (cfg.src_width == 16'd0) || (cfg.rect_height == 8'd0);
   assign screen_col = {9'd0, cfg.dest_x} + {1'b0, column_count_ff};
   assign screen_row = {1'b0, cfg.dest_y} + {1'b0, row_count_ff};

   // Clip against the right and bottom edges
   assign emit = !size_zero && ({1'b0, cfg.dest_y} <= SCREEN_LAST)
              && (screen_col <= COLUMN_LAST) && (screen_row <= SCREEN_LAST);

   always_comb begin
      result.buffer_sel  = cfg.target_buffer;
      result.bank_sel    = screen_row[BANK_BITS+1:BANK_BITS];
      result.bank_offset = {screen_row[BANK_BITS-1:0], screen_col[7:0]};
      result.pixel_out   = pixel_in;
   end

   // Advance the counters, wrapping at the rectangle edges
   assign column_next = {1'b0, column_count_ff} + 17'd1;
   assign row_next    = {1'b0, row_count_ff} + 9'd1;

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (advance) begin
         if (size_zero) begin
            column_count_in = '0;
            row_count_in    = '0;
         end else if (column_next >= {1'b0, cfg.src_width}) begin
            column_count_in = '0;
            if (row_next >= {1'b0, cfg.rect_height}) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_next[7:0];
            end
         end else begin
            column_count_in = column_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule

// ===== design/cbba_out.sv =====
// Output register for frame buffer write transactions.
module cbba_out
   import cbba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic       load_valid,
   input  result_type load_data,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // Hold while stalled, drop once taken, refill on a new input
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = load_valid;
         rsp_data_in  = load_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the clipped banked blit addresser.
module testbench;
   import cbba_pkg::*;

   localparam int LONG_HOLD      = 60;
   localparam int SETTLE_CYCLES  = 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PIXEL_TARGET   = 850;
   localparam int TAIL_START     = 720;
   localparam int MAX_REPORTS    = 10;

   typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} step_check_type;

   typedef struct {
      step_kind_type  kind;
      reg_index_type  idx;
      logic [15:0]    value;
      logic [7:0]     pixel;
      step_check_type chk;
      result_type     wr;
   } blit_step_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_pixel_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_buffer_sel;
   logic [1:0]            rsp_bank_sel;
   logic [13:0]           rsp_bank_offset;
   logic [7:0]            rsp_pixel_out;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Expectation pinned to the pixel currently offered
   step_check_type pin_check;
   result_type     pin_write;

   // Shadow configuration and source position counters
   cfg_type     blit_cfg;
   logic [15:0] src_col;
   logic [7:0]  src_row;

   result_type    pending_writes[$];
   blit_step_type directed_steps[$];

   logic long_hold;
   logic quiet_tail;
   int   pixels_sent;
   int   writes_checked;
   int   cfg_writes;
   int   phases;
   int   mismatch_count;
   int   quiet_cycles;

   clipped_banked_blit_addresser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_buffer_sel  (rsp_buffer_sel),
      .rsp_bank_sel    (rsp_bank_sel),
      .rsp_bank_offset (rsp_bank_offset),
      .rsp_pixel_out   (rsp_pixel_out),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Work out the frame-buffer write for one pixel and advance the counters
   function automatic bit predict_write(input logic [7:0] pixel, output result_type wr);
      int scr_col;
      int scr_row;
      bit hit;
      wr  = '0;
      hit = 1'b0;
      if (blit_cfg.src_width == 0 || blit_cfg.rect_height == 0) begin
         src_col = '0;
         src_row = '0;
         return 1'b0;
      end
      scr_col = int'(blit_cfg.dest_x) + int'(src_col);
      scr_row = int'(blit_cfg.dest_y) + int'(src_row);
      if (int'(blit_cfg.dest_y) <= SCREEN_LINES - 1 && scr_col <= 255 &&
          scr_row <= SCREEN_LINES - 1) begin
         hit            = 1'b1;
         wr.buffer_sel  = blit_cfg.target_buffer;
         wr.bank_sel    = 2'(scr_row / BANK_LINES);
         wr.bank_offset = 14'((scr_row % BANK_LINES) * 256 + scr_col);
         wr.pixel_out   = pixel;
      end
      // Wrap column at row end, wrap row at rectangle end
      if (int'(src_col) + 1 >= int'(blit_cfg.src_width)) begin
         src_col = '0;
         if (int'(src_row) + 1 >= int'(blit_cfg.rect_height)) src_row = '0;
         else src_row = src_row + 8'd1;
      end else begin
         src_col = src_col + 16'd1;
      end
      return hit;
   endfunction

   function automatic blit_step_type cfg_step(input reg_index_type idx,
                                              input logic [15:0] value);
      blit_step_type s;
      s       = '{STEP_CFG, idx, value, 8'd0, CHK_NONE, '0};
      return s;
   endfunction

   function automatic blit_step_type pixel_step(input logic [7:0] pixel,
                                                input step_check_type chk,
                                                input logic buf_sel, input logic [1:0] bank,
                                                input logic [13:0] offset);
      blit_step_type s;
      s = '{STEP_PIXEL, REG_DEST_X, 16'd0, pixel, chk, '{buf_sel, bank, offset, pixel}};
      return s;
   endfunction

   // Offer one pixel, with an occasional gap in front, and hold it until taken
   task automatic send_pixel(input logic [7:0] pixel, input step_check_type chk,
                             input result_type wr, input bit gaps);
      if (gaps && !quiet_tail && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pixel;
      pin_check    <= chk;
      pin_write    <= wr;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // Drop valid and wait until every expected write has come back
   task automatic drain_writes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup and access phases, then an idle gap so writes never abut
   task automatic csr_write(input reg_index_type idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_DEST_X:        blit_cfg.dest_x        = value[7:0];
         REG_DEST_Y:        blit_cfg.dest_y        = value[7:0];
         REG_SRC_WIDTH:     blit_cfg.src_width     = value;
         REG_RECT_HEIGHT:   blit_cfg.rect_height   = value[7:0];
         REG_TARGET_BUFFER: blit_cfg.target_buffer = value[0];
         default: ;
      endcase
      cfg_writes++;
      @(posedge clock);
   endtask

   // Receiver: random stall bursts, one long hold on request, none in the tail
   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold <= 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Check finished writes, then queue the write for each accepted pixel
   always @(posedge clock) begin
      result_type want;
      result_type model_wr;
      bit         model_hit;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            writes_checked++;
            if (pending_writes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected write buf=%0d bank=%0d ofs=%0d pix=%02h", $time,
                           rsp_buffer_sel, rsp_bank_sel, rsp_bank_offset, rsp_pixel_out);
            end else begin
               want = pending_writes.pop_front();
               if (rsp_buffer_sel !== want.buffer_sel || rsp_bank_sel !== want.bank_sel ||
                   rsp_bank_offset !== want.bank_offset || rsp_pixel_out !== want.pixel_out) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: write mismatch, expected buf=%0d bank=%0d ofs=%0d pix=%02h,",
                              $time, want.buffer_sel, want.bank_sel, want.bank_offset,
                              want.pixel_out,
                              " got buf=%0d bank=%0d ofs=%0d pix=%02h", rsp_buffer_sel,
                              rsp_bank_sel, rsp_bank_offset, rsp_pixel_out);
               end
            end
         end
         if (req_valid && !req_stall) begin
            model_hit = predict_write(req_pixel_in, model_wr);
            case (pin_check)
               CHK_MODEL: if (model_hit) pending_writes.push_back(model_wr);
               CHK_FIXED: pending_writes.push_back(pin_write);
               default: ;
            endcase
         end
      end
   end

   // Watchdog: end the run after too long without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      int n_items;
      int area;
      logic [15:0] value;
      reg_index_type idx;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_in   = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      pin_check      = CHK_MODEL;
      pin_write      = '0;
      long_hold      = 1'b0;
      quiet_tail     = 1'b0;
      pixels_sent    = 0;
      writes_checked = 0;
      cfg_writes     = 0;
      phases         = 0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      blit_cfg       = '{8'd0, 8'd0, 16'd1, 8'd1, 1'b0};
      src_col        = '0;
      src_row        = '0;

      // Directed steps: reset defaults, corner pixel, clipping, zero sizes,
      // off-screen bottom edge, stale counters after a shrink, bank boundary
      directed_steps.push_back(pixel_step(8'hA5, CHK_FIXED, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(pixel_step(8'h5A, CHK_FIXED, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(cfg_step(REG_DEST_X, 16'd255));
      directed_steps.push_back(cfg_step(REG_DEST_Y, 16'd191));
      directed_steps.push_back(cfg_step(REG_SRC_WIDTH, 16'd2));
      directed_steps.push_back(cfg_step(REG_RECT_HEIGHT, 16'd2));
      directed_steps.push_back(cfg_step(REG_TARGET_BUFFER, 16'd1));
      directed_steps.push_back(pixel_step(8'hFF, CHK_FIXED, 1'b1, 2'd2, 14'd16383));
      directed_steps.push_back(pixel_step(8'h00, CHK_NONE, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(pixel_step(8'h01, CHK_NONE, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(pixel_step(8'h02, CHK_NONE, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(pixel_step(8'h80, CHK_FIXED, 1'b1, 2'd2, 14'd16383));
      directed_steps.push_back(cfg_step(REG_DEST_Y, 16'd192));
      directed_steps.push_back(pixel_step(8'h11, CHK_NONE, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(pixel_step(8'h22, CHK_NONE, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(cfg_step(REG_DEST_Y, 16'd255));
      directed_steps.push_back(pixel_step(8'h33, CHK_NONE, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(cfg_step(REG_SRC_WIDTH, 16'd0));
      directed_steps.push_back(pixel_step(8'h44, CHK_NONE, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(cfg_step(REG_DEST_X, 16'd0));
      directed_steps.push_back(cfg_step(REG_DEST_Y, 16'd0));
      directed_steps.push_back(cfg_step(REG_SRC_WIDTH, 16'd65535));
      directed_steps.push_back(cfg_step(REG_RECT_HEIGHT, 16'd255));
      directed_steps.push_back(cfg_step(REG_TARGET_BUFFER, 16'd0));
      directed_steps.push_back(pixel_step(8'h55, CHK_FIXED, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(pixel_step(8'h66, CHK_MODEL, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(pixel_step(8'h77, CHK_MODEL, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(cfg_step(REG_SRC_WIDTH, 16'd2));
      directed_steps.push_back(pixel_step(8'h88, CHK_FIXED, 1'b0, 2'd0, 14'd3));
      directed_steps.push_back(pixel_step(8'h99, CHK_FIXED, 1'b0, 2'd0, 14'd256));
      directed_steps.push_back(cfg_step(REG_RECT_HEIGHT, 16'd0));
      directed_steps.push_back(pixel_step(8'hAA, CHK_NONE, 1'b0, 2'd0, 14'd0));
      directed_steps.push_back(cfg_step(REG_DEST_X, 16'd128));
      directed_steps.push_back(cfg_step(REG_DEST_Y, 16'd64));
      directed_steps.push_back(cfg_step(REG_RECT_HEIGHT, 16'd1));
      directed_steps.push_back(pixel_step(8'hBB, CHK_FIXED, 1'b0, 2'd1, 14'd128));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed steps; drain before each group of register writes
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CFG) begin
            if (i > 0 && directed_steps[i-1].kind == STEP_PIXEL) drain_writes();
            csr_write(directed_steps[i].idx, directed_steps[i].value);
         end else begin
            send_pixel(directed_steps[i].pixel, directed_steps[i].chk,
                       directed_steps[i].wr, 1'b1);
         end
      end

      // Back-pressure: every pixel lands, receiver holds off for a long stretch
      drain_writes();
      csr_write(REG_DEST_X, 16'd0);
      csr_write(REG_DEST_Y, 16'd0);
      csr_write(REG_SRC_WIDTH, 16'd16);
      csr_write(REG_RECT_HEIGHT, 16'd4);
      csr_write(REG_TARGET_BUFFER, 16'd1);
      long_hold <= 1'b1;
      repeat (40) send_pixel(8'($urandom_range(0, 255)), CHK_MODEL, '0, 1'b0);

      // Random phases: rewrite a random subset of registers, then stream pixels
      while (pixels_sent < PIXEL_TARGET) begin
         drain_writes();
         if (pixels_sent >= TAIL_START) quiet_tail <= 1'b1;
         for (int r = REG_DEST_X; r <= REG_TARGET_BUFFER; r++) begin
            idx = reg_index_type'(r);
            if ($urandom_range(0, 1) == 0) continue;
            case (idx)
               REG_DEST_X:
                  case ($urandom_range(0, 5))
                     0: value = 16'd0;
                     1: value = 16'd255;
                     2: value = 16'($urandom_range(240, 255));
                     default: value = 16'($urandom_range(0, 255));
                  endcase
               REG_DEST_Y:
                  case ($urandom_range(0, 7))
                     0: value = 16'd0;
                     1: value = 16'd191;
                     2: value = 16'($urandom_range(192, 255));
                     3: value = 16'($urandom_range(180, 191));
                     default: value = 16'($urandom_range(0, 191));
                  endcase
               REG_SRC_WIDTH:
                  case ($urandom_range(0, 11))
                     0: value = 16'd0;
                     1: value = 16'd65535;
                     2: value = 16'($urandom_range(250, 300));
                     default: value = 16'($urandom_range(1, 24));
                  endcase
               REG_RECT_HEIGHT:
                  case ($urandom_range(0, 11))
                     0: value = 16'd0;
                     1: value = 16'd255;
                     default: value = 16'($urandom_range(1, 12));
                  endcase
               default: value = 16'($urandom_range(0, 1));
            endcase
            csr_write(idx, value);
         end
         // Prefer whole rectangles, once or twice over, when they are small
         area = int'(blit_cfg.src_width) * int'(blit_cfg.rect_height);
         if (area != 0 && area <= 60) n_items = area * $urandom_range(1, 2);
         else n_items = $urandom_range(8, 60);
         repeat (n_items) send_pixel(8'($urandom_range(0, 255)), CHK_MODEL, '0, 1'b1);
         phases++;
      end

      drain_writes();
      if (pending_writes.size() != 0) begin
         mismatch_count += pending_writes.size();
         $display("%0d expected writes never arrived", pending_writes.size());
      end
      $display("Streamed %0d pixels over %0d random register phases, %0d register writes",
               pixels_sent, phases, cfg_writes);
      $display("Checked %0d frame-buffer writes, %0d mismatches", writes_checked,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
